FILE: src/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: src/llbc_pkg.sv
// package for the locked lru buffer cache
// types and constants used by the cell and the top level
package llbc_pkg;
    localparam int SLOTS_DEF     = 16;
    localparam int LOCK_BITS_DEF = 8;
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SLOT  = 3'd1;
    localparam logic [2:0] ST_NOT_FND  = 3'd2;
    localparam logic [2:0] ST_UNDERFL  = 3'd3;
    localparam logic [2:0] ST_OVERFL   = 3'd4;
    localparam logic       CFG_STATIC  = 1'b0;
    localparam logic       CFG_EXTRA   = 1'b1;
    localparam logic       FN_LOCK     = 1'b0;
    localparam logic       FN_UNLOCK   = 1'b1;
    localparam logic [24:0] GROUP_NONE = 25'h1FFFFFF;
    localparam logic [15:0] SHORT_NONE = 16'hFFFF;

    // command broadcast to all cells
    typedef struct packed {
        logic        init;
        logic        wr;
        logic        lock;
        logic        clr;
        logic [31:0] stamp;
        logic [24:0] grp;
        logic [15:0] itm;
        logic [15:0] blk;
    } cell_cmd_t;
endpackage

FILE: src/llbc_cell.sv
// one slot of the tag table, part of a rotating ring of cells
// depends on llbc_pkg
module llbc_cell
    import llbc_pkg::*;
#(
    parameter int LOCK_BITS = LOCK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,
    input  logic                 init_valid,
    input  logic                 prev_valid,
    input  logic [LOCK_BITS-1:0] prev_locks,
    input  logic [31:0]          prev_use,
    input  logic [24:0]          prev_grp,
    input  logic [15:0]          prev_itm,
    input  logic [15:0]          prev_blk,
    input  cell_cmd_t            cmd,
    output logic                 valid,
    output logic [LOCK_BITS-1:0] locks,
    output logic [31:0]          last_use,
    output logic [24:0]          grp,
    output logic [15:0]          itm,
    output logic [15:0]          blk
);
    logic                 valid_reg, valid_next;
    logic [LOCK_BITS-1:0] locks_reg, locks_next;
    logic [31:0]          use_reg, use_next;
    logic [24:0]          grp_reg, grp_next;
    logic [15:0]          itm_reg, itm_next;
    logic [15:0]          blk_reg, blk_next;

    // cmd.wr reaches only the head cell (the top level gates it); others just rotate or hold
    always_comb
    begin
        valid_next = valid_reg;
        locks_next = locks_reg;
        use_next   = use_reg;
        grp_next   = grp_reg;
        itm_next   = itm_reg;
        blk_next   = blk_reg;
        if (cmd.init)
        begin
            valid_next = init_valid;
            locks_next = '0;
            use_next   = '0;
            grp_next   = GROUP_NONE;
            itm_next   = SHORT_NONE;
            blk_next   = SHORT_NONE;
        end
        else if (shift)
        begin
            valid_next = prev_valid;
            locks_next = prev_locks;
            use_next   = prev_use;
            grp_next   = prev_grp;
            itm_next   = prev_itm;
            blk_next   = prev_blk;
        end
        else if (cmd.wr)
        begin
            use_next = cmd.stamp;
            if (cmd.clr)
            begin
                valid_next = 1'b0;
                locks_next = '0;
                use_next   = '0;
                grp_next   = GROUP_NONE;
                itm_next   = SHORT_NONE;
                blk_next   = SHORT_NONE;
            end
            else if (cmd.lock)
            begin
                valid_next = 1'b1;
                locks_next = locks_reg + 1'b1;
                grp_next   = cmd.grp;
                itm_next   = cmd.itm;
                blk_next   = cmd.blk;
            end
            else
            begin
                locks_next = locks_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= init_valid;
            locks_reg <= '0;
            use_reg   <= '0;
            grp_reg   <= GROUP_NONE;
            itm_reg   <= SHORT_NONE;
            blk_reg   <= SHORT_NONE;
        end
        else
        begin
            valid_reg <= valid_next;
            locks_reg <= locks_next;
            use_reg   <= use_next;
            grp_reg   <= grp_next;
            itm_reg   <= itm_next;
            blk_reg   <= blk_next;
        end
    end

    assign valid    = valid_reg;
    assign locks    = locks_reg;
    assign last_use = use_reg;
    assign grp      = grp_reg;
    assign itm      = itm_reg;
    assign blk      = blk_reg;
endmodule

FILE: src/locked_lru_buffer_cache_top.sv
// top level of the locked lru buffer cache: ring of slot cells and scan control
// depends on llbc_pkg, llbc_cell and assert_macros.svh
//
// A request (start while not busy) runs through two full turns of the slot
// table, which is a ring of SLOTS cells rotating one place per cycle unless
// held: one turn scans every slot past the head cell, the S_DONE state
// decides, and a second turn brings the chosen slot to the head, where it is
// written, if the decision calls for a write, with the ring held. The result
// is shown for one cycle with done high and cannot be held; busy is low in
// that cycle, so the next request may start.
// Configuration writes are taken only while idle and reinitialize the table.
`include "assert_macros.svh"
module locked_lru_buffer_cache_top
    import llbc_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int LOCK_BITS = LOCK_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [23:0] group_id,
    input  logic [14:0] item_id,
    input  logic [14:0] block_id,
    output logic        done,
    output logic [3:0]  slot,
    output logic        hit,
    output logic        fill_needed,
    output logic [2:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SEEK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX = '1;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  stat_cfg_reg;
    logic [3:0]  extra_cfg_reg;
    logic [IW-1:0] pos_reg, pos_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [31:0] clock_reg, clock_next;
    logic        func_reg;
    logic [24:0] g_reg;
    logic [15:0] i_reg, b_reg;
    logic        hit_found_reg, hit_found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic        sf_reg, sf_next;
    logic [IW-1:0] sidx_reg, sidx_next;
    logic [31:0] sold_reg, sold_next;
    logic        ef_reg, ef_next;
    logic [IW-1:0] eidx_reg, eidx_next;
    logic [LOCK_BITS-1:0] hlocks_reg, hlocks_next;
    logic        dec_wr_reg, dec_wr_next;
    logic        dec_lock_reg, dec_lock_next;
    logic        dec_clr_reg, dec_clr_next;
    logic [IW-1:0] tgt_reg, tgt_next;
    logic        done_reg, done_next;
    logic [3:0]  slot_reg, slot_next;
    logic        hit_reg, hit_next;
    logic        fill_reg, fill_next;
    logic [2:0]  status_reg, status_next;

    logic [CW-1:0] n_stat, n_tot;
    logic [5:0]    sum6;
    logic          cfg_wr;
    cell_cmd_t     cmd;
    logic          shift;

    logic                 c_valid [SLOTS];
    logic [LOCK_BITS-1:0] c_locks [SLOTS];
    logic [31:0]          c_use   [SLOTS];
    logic [24:0]          c_grp   [SLOTS];
    logic [15:0]          c_itm   [SLOTS];
    logic [15:0]          c_blk   [SLOTS];
    logic                 init_v  [SLOTS];
    logic                 wr_here;

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign n_stat = (32'(stat_cfg_reg) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(stat_cfg_reg);
    assign sum6   = 6'(n_stat) + 6'(extra_cfg_reg);
    assign n_tot  = (32'(sum6) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(sum6);

    // cell 0 is the head; cell k holds slot (pos + k) mod SLOTS
    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            localparam int PV = (k + 1) % SLOTS;
            logic [IW:0] sidx;
            cell_cmd_t   kcmd;
            always_comb
            begin
                kcmd = cmd;
                kcmd.wr = (k == 0) ? wr_here : 1'b0;
            end
            // after init the ring is at pos 0 so cell k holds slot k
            assign sidx = (IW+1)'(k);
            assign init_v[k] = ({1'b0, sidx} < (IW+2)'(n_stat));
            llbc_cell #(.LOCK_BITS(LOCK_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .init_valid (init_v[k]),
                .prev_valid (c_valid[PV]),
                .prev_locks (c_locks[PV]),
                .prev_use   (c_use[PV]),
                .prev_grp   (c_grp[PV]),
                .prev_itm   (c_itm[PV]),
                .prev_blk   (c_blk[PV]),
                .cmd        (kcmd),
                .valid      (c_valid[k]),
                .locks      (c_locks[k]),
                .last_use   (c_use[k]),
                .grp        (c_grp[k]),
                .itm        (c_itm[k]),
                .blk        (c_blk[k])
            );
        end
    endgenerate

    logic head_in_tot, head_in_stat, tag_eq;
    assign head_in_tot  = (CW'(pos_reg) < n_tot);
    assign head_in_stat = (CW'(pos_reg) < n_stat);
    assign tag_eq = c_valid[0] && c_grp[0] == g_reg && c_itm[0] == i_reg
                    && c_blk[0] == b_reg;
    assign wr_here = (state_reg == S_SEEK) && dec_wr_reg && (pos_reg == tgt_reg);
    assign shift = !cfg_wr && !wr_here && ((state_reg == S_SCAN) || (state_reg == S_SEEK));

    always_comb
    begin
        cmd       = '0;
        cmd.init  = cfg_wr;
        cmd.lock  = dec_lock_reg;
        cmd.clr   = dec_clr_reg;
        cmd.stamp = clock_reg;
        cmd.grp   = g_reg;
        cmd.itm   = i_reg;
        cmd.blk   = b_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        clock_next     = clock_reg;
        hit_found_next = hit_found_reg;
        hit_idx_next   = hit_idx_reg;
        sf_next        = sf_reg;
        sidx_next      = sidx_reg;
        sold_next      = sold_reg;
        ef_next        = ef_reg;
        eidx_next      = eidx_reg;
        hlocks_next    = hlocks_reg;
        dec_wr_next    = dec_wr_reg;
        dec_lock_next  = dec_lock_reg;
        dec_clr_next   = dec_clr_reg;
        tgt_next       = tgt_reg;
        done_next      = 1'b0;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        fill_next      = fill_reg;
        status_next    = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next     = S_SCAN;
                    cnt_next       = '0;
                    clock_next     = clock_reg + 32'd1;
                    hit_found_next = 1'b0;
                    sf_next        = 1'b0;
                    ef_next        = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (head_in_tot && tag_eq && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = pos_reg;
                    hlocks_next    = c_locks[0];
                end
                if (head_in_stat && c_locks[0] == '0
                    && (!sf_reg || c_use[0] < sold_reg
                        || (c_use[0] == sold_reg && pos_reg < sidx_reg)))
                begin
                    sf_next   = 1'b1;
                    sidx_next = pos_reg;
                    sold_next = c_use[0];
                end
                if (head_in_tot && !head_in_stat && c_locks[0] == '0
                    && (!ef_reg || pos_reg < eidx_reg))
                begin
                    ef_next   = 1'b1;
                    eidx_next = pos_reg;
                end
                pos_next = (pos_reg == IW'(SLOTS - 1)) ? '0 : pos_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // decide the outcome; the ring is back at its start position
                dec_wr_next  = 1'b0;
                dec_lock_next = (func_reg == FN_LOCK);
                dec_clr_next = 1'b0;
                hit_next     = 1'b0;
                fill_next    = 1'b0;
                slot_next    = '0;
                status_next  = ST_OK;
                if (func_reg == FN_LOCK)
                begin
                    if (hit_found_reg)
                    begin
                        hit_next  = 1'b1;
                        slot_next = 4'(hit_idx_reg);
                        tgt_next  = hit_idx_reg;
                        if (hlocks_reg == LOCK_MAX)
                            status_next = ST_OVERFL;
                        else
                            dec_wr_next = 1'b1;
                    end
                    else if (sf_reg || ef_reg)
                    begin
                        tgt_next    = sf_reg ? sidx_reg : eidx_reg;
                        slot_next   = 4'(sf_reg ? sidx_reg : eidx_reg);
                        fill_next   = 1'b1;
                        dec_wr_next = 1'b1;
                    end
                    else
                        status_next = ST_NO_SLOT;
                end
                else
                begin
                    if (!hit_found_reg)
                        status_next = ST_NOT_FND;
                    else
                    begin
                        slot_next = 4'(hit_idx_reg);
                        tgt_next  = hit_idx_reg;
                        if (hlocks_reg == '0)
                            status_next = ST_UNDERFL;
                        else
                        begin
                            dec_wr_next  = 1'b1;
                            dec_clr_next = (hlocks_reg == LOCK_BITS'(1))
                                && !(CW'(hit_idx_reg) < n_stat);
                        end
                    end
                end
                cnt_next   = '0;
                state_next = S_SEEK;
            end
            S_SEEK:
            begin
                // rotate one full turn, writing the head as the target passes
                if (wr_here)
                    dec_wr_next = 1'b0;
                else
                begin
                    pos_next = (pos_reg == IW'(SLOTS - 1)) ? '0 : pos_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IW'(SLOTS - 1))
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_cfg_reg  <= 5'd8;
            extra_cfg_reg <= 4'd8;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            clock_reg     <= '0;
            hit_found_reg <= 1'b0;
            sf_reg        <= 1'b0;
            ef_reg        <= 1'b0;
            dec_wr_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            clock_reg     <= clock_next;
            hit_found_reg <= hit_found_next;
            sf_reg        <= sf_next;
            ef_reg        <= ef_next;
            dec_wr_reg    <= dec_wr_next;
            done_reg      <= done_next;
            if (cfg_wr && cfg_index == CFG_STATIC)
                stat_cfg_reg <= cfg_data;
            if (cfg_wr && cfg_index == CFG_EXTRA)
                extra_cfg_reg <= cfg_data[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            func_reg <= func;
            g_reg    <= {1'b0, group_id};
            i_reg    <= {1'b0, item_id};
            b_reg    <= {1'b0, block_id};
        end
        hit_idx_reg  <= hit_idx_next;
        sidx_reg     <= sidx_next;
        sold_reg     <= sold_next;
        eidx_reg     <= eidx_next;
        hlocks_reg   <= hlocks_next;
        dec_lock_reg <= dec_lock_next;
        dec_clr_reg  <= dec_clr_next;
        tgt_reg      <= tgt_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        fill_reg     <= fill_next;
        status_reg   <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign slot        = slot_reg;
    assign hit         = hit_reg;
    assign fill_needed = fill_reg;
    assign status      = status_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "busy must follow start")
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "done while busy")
    `ASSERT_IMPL(a_hit_fill, clk, rst_n, done, !(hit && fill_needed), "hit and fill together")
    `ASSERT_IMPL(a_wr_seek, clk, rst_n, wr_here, state_reg == S_SEEK, "head write outside seek")
endmodule

FILE: verif/locked_lru_buffer_cache_top_tb.sv
// testbench for locked_lru_buffer_cache_top: directed and random lock/unlock requests
// predicts each result with a slot table model held in a scoreboard class
// depends on llbc_pkg and the rtl of locked_lru_buffer_cache_top
module locked_lru_buffer_cache_top_tb;
    import llbc_pkg::*;

    localparam int NSLOT = 16;
    localparam int LOCK_LIMIT = 255;
    localparam int MAX_CYCLES = 600000;

    typedef struct packed {
        logic [3:0] slot;
        logic       hit;
        logic       fill;
        logic [2:0] status;
    } cache_resp_t;

    class slot_table_sb;
        int unsigned n_static;
        int unsigned n_extra;
        bit          valid [NSLOT];
        int unsigned locks [NSLOT];
        bit [31:0]   stamp [NSLOT];
        bit [24:0]   gtag [NSLOT];
        bit [15:0]   itag [NSLOT];
        bit [15:0]   btag [NSLOT];
        bit [31:0]   req_clock;
        cache_resp_t pending [$];
        int          errors;

        function new();
            n_static = 8;
            n_extra = 8;
            req_clock = 0;
            errors = 0;
            clear_table();
        endfunction

        function int unsigned statics();
            return n_static > NSLOT ? NSLOT : n_static;
        endfunction

        function int unsigned total();
            int unsigned t;
            t = statics() + n_extra;
            return t > NSLOT ? NSLOT : t;
        endfunction

        function void empty_slot(int i, bit v);
            valid[i] = v;
            locks[i] = 0;
            stamp[i] = 0;
            gtag[i] = GROUP_NONE;
            itag[i] = SHORT_NONE;
            btag[i] = SHORT_NONE;
        endfunction

        function void clear_table();
            for (int i = 0; i < NSLOT; i++)
                empty_slot(i, i < statics());
        endfunction

        function void set_reg(logic idx, logic [4:0] val);
            if (idx == CFG_STATIC)
                n_static = 32'(val);
            else
                n_extra = 32'(val[3:0]);
            clear_table();
        endfunction

        function void note_request(logic fn, logic [23:0] g, logic [14:0] it, logic [14:0] bl);
            cache_resp_t r;
            int          s;
            int          best;
            bit          found;
            bit [31:0]   oldest;
            s = -1;
            found = 0;
            best = 0;
            oldest = 0;
            for (int i = 0; i < total(); i++)
                if (s < 0 && valid[i] && gtag[i] == {1'b0, g} && itag[i] == {1'b0, it}
                    && btag[i] == {1'b0, bl})
                    s = i;
            req_clock++;
            r = '0;
            if (fn == FN_LOCK) begin
                if (s >= 0) begin
                    r.slot = 4'(s);
                    r.hit = 1;
                    if (locks[s] >= LOCK_LIMIT)
                        r.status = ST_OVERFL;
                    else begin
                        stamp[s] = req_clock;
                        locks[s]++;
                        r.status = ST_OK;
                    end
                end else begin
                    for (int i = 0; i < statics(); i++)
                        if (locks[i] == 0 && (!found || stamp[i] < oldest)) begin
                            found = 1;
                            best = i;
                            oldest = stamp[i];
                        end
                    if (!found)
                        for (int i = statics(); i < total(); i++)
                            if (!found && locks[i] == 0) begin
                                found = 1;
                                best = i;
                            end
                    if (!found)
                        r.status = ST_NO_SLOT;
                    else begin
                        valid[best] = 1;
                        gtag[best] = {1'b0, g};
                        itag[best] = {1'b0, it};
                        btag[best] = {1'b0, bl};
                        stamp[best] = req_clock;
                        locks[best] = 1;
                        r.slot = 4'(best);
                        r.fill = 1;
                        r.status = ST_OK;
                    end
                end
            end else if (s < 0) begin
                r.status = ST_NOT_FND;
            end else begin
                r.slot = 4'(s);
                if (locks[s] == 0)
                    r.status = ST_UNDERFL;
                else begin
                    stamp[s] = req_clock;
                    locks[s]--;
                    if (locks[s] == 0 && s >= statics())
                        empty_slot(s, 0);
                    r.status = ST_OK;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(cache_resp_t got);
            cache_resp_t want;
            if (pending.size() == 0) begin
                report_error("result with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.slot !== want.slot)
                report_error($sformatf("slot %0d want %0d", got.slot, want.slot));
            if (got.hit !== want.hit)
                report_error($sformatf("hit %0b want %0b", got.hit, want.hit));
            if (got.fill !== want.fill)
                report_error($sformatf("fill_needed %0b want %0b", got.fill, want.fill));
            if (got.status !== want.status)
                report_error($sformatf("status %0d want %0d", got.status, want.status));
        endfunction

        function void report_error(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [23:0] group_id;
    logic [14:0] item_id;
    logic [14:0] block_id;
    logic        done;
    logic [3:0]  slot;
    logic        hit;
    logic        fill_needed;
    logic [2:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    slot_table_sb sb;
    int           idle_pct;
    longint       cycles;
    logic [23:0]  grp_pool [4];
    logic [14:0]  itm_pool [4];

    locked_lru_buffer_cache_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .group_id(group_id), .item_id(item_id), .block_id(block_id), .done(done),
        .slot(slot), .hit(hit), .fill_needed(fill_needed), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            sb.check_result('{slot: slot, hit: hit, fill: fill_needed, status: status});
        if (cycles > MAX_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic fn, logic [23:0] g, logic [14:0] it, logic [14:0] bl);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1;
        func <= fn;
        group_id <= g;
        item_id <= it;
        block_id <= bl;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(fn, g, it, bl);
        start <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 0;
    endtask

    task automatic random_request(int pool);
        logic [14:0] bl;
        int          k;
        k = $urandom_range(pool - 1);
        bl = 15'($urandom_range(7));
        if ($urandom_range(19) == 0)
            send_request(1'($urandom_range(1)), 24'($urandom), 15'($urandom),
                15'($urandom));
        else
            send_request($urandom_range(99) < 55 ? FN_LOCK : FN_UNLOCK,
                grp_pool[k], itm_pool[k], bl);
    endtask

    task automatic random_phase(int n, int pool);
        for (int i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                idle_pct = (i / 60) % 4 == 0 ? 0 : ((i / 60) % 4 == 1 ? 83 : 29);
            random_request(pool);
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        rst_n = 0;
        start = 0;
        func = 0;
        group_id = 0;
        item_id = 0;
        block_id = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        for (int i = 0; i < 4; i++)
        begin
            grp_pool[i] = 24'($urandom);
            itm_pool[i] = 15'($urandom);
        end
        grp_pool[0] = 24'hFFFFFF;
        itm_pool[0] = 15'h7FFF;
        grp_pool[1] = 0;
        itm_pool[1] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, hit, miss, underflow, not found, extra slots
        send_request(FN_LOCK, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        send_request(FN_LOCK, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        send_request(FN_LOCK, 0, 0, 0);
        send_request(FN_UNLOCK, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        send_request(FN_UNLOCK, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        send_request(FN_UNLOCK, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
        send_request(FN_UNLOCK, 24'h123456, 15'h1234, 15'h0042);
        send_request(FN_UNLOCK, 0, 0, 0);
        write_reg(CFG_STATIC, 1);
        write_reg(CFG_EXTRA, 1);
        send_request(FN_LOCK, 1, 1, 1);
        send_request(FN_LOCK, 2, 2, 2);
        send_request(FN_LOCK, 3, 3, 3);
        send_request(FN_UNLOCK, 2, 2, 2);
        send_request(FN_UNLOCK, 2, 2, 2);
        // lock count overflow on one slot
        for (int i = 0; i < 256; i++)
            send_request(FN_LOCK, 1, 1, 1);
        write_reg(CFG_STATIC, 0);
        write_reg(CFG_EXTRA, 0);
        send_request(FN_LOCK, 5, 5, 5);
        write_reg(CFG_STATIC, 31);
        write_reg(CFG_EXTRA, 15);
        send_request(FN_LOCK, 5, 5, 5);

        write_reg(CFG_STATIC, 8);
        write_reg(CFG_EXTRA, 8);
        random_phase(320, 4);
        write_reg(CFG_STATIC, 2);
        write_reg(CFG_EXTRA, 3);
        random_phase(280, 3);
        write_reg(CFG_STATIC, 16);
        write_reg(CFG_EXTRA, 0);
        random_phase(200, 4);
        write_reg(CFG_STATIC, 0);
        write_reg(CFG_EXTRA, 4);
        random_phase(160, 2);
        write_reg(CFG_STATIC, 5);
        write_reg(CFG_EXTRA, 15);
        random_phase(220, 4);

        idle_pct = 0;
        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
